// ===== rtl/core/vtx_pkg.sv =====
// ============================================================================
// vtx_pkg : shared types and constants of the 4x4 vertex transform
// Widths of the bus fields, register map and the stage enable bundle that the
// top level hands to the row lanes.
// ============================================================================
package vtx_pkg;

   // Bus field widths (fixed by the stream and register formats)
   localparam int DATA_WIDTH     = 32;                  // one vector component
   localparam int NUM_COMP       = 4;                   // components per vector
   localparam int TDATA_WIDTH    = DATA_WIDTH * NUM_COMP;
   localparam int CFG_DATA_WIDTH = 64;
   localparam int NUM_REGS       = 8;
   localparam int REG_IDX_WIDTH  = 3;
   localparam int ADDR_LSB       = 3;                   // 8-byte register stride
   localparam int CSR_ADDR_WIDTH = REG_IDX_WIDTH + ADDR_LSB;
   localparam int ODD_ENTRY_LSB  = 32;                  // odd column in upper half

   // Register map
   localparam logic [REG_IDX_WIDTH-1:0] REG_ROW0_COLS01 = 3'd0;
   localparam logic [REG_IDX_WIDTH-1:0] REG_ROW0_COLS23 = 3'd1;
   localparam logic [REG_IDX_WIDTH-1:0] REG_ROW1_COLS01 = 3'd2;
   localparam logic [REG_IDX_WIDTH-1:0] REG_ROW1_COLS23 = 3'd3;
   localparam logic [REG_IDX_WIDTH-1:0] REG_ROW2_COLS01 = 3'd4;
   localparam logic [REG_IDX_WIDTH-1:0] REG_ROW2_COLS23 = 3'd5;
   localparam logic [REG_IDX_WIDTH-1:0] REG_ROW3_COLS01 = 3'd6;
   localparam logic [REG_IDX_WIDTH-1:0] REG_ROW3_COLS23 = 3'd7;

   // Pipeline stage positions in the valid vector
   localparam int STG_MUL  = 0;
   localparam int STG_PAIR = 1;
   localparam int STG_SUM  = 2;
   localparam int STG_OUT  = 3;
   localparam int NUM_STG  = 4;

   // Load enables for the lane stages
   typedef struct packed {
      logic mul_en;
      logic pair_en;
      logic sum_en;
   } vtx_stage_en_type;

endpackage : vtx_pkg

// ===== rtl/core/vtx_csr.sv =====
// ============================================================================
// vtx_csr : matrix register file
// Eight 64-bit registers holding the row-major matrix, two entries each,
// written and read over an APB-style port. Resets to the identity matrix.
// ============================================================================
module vtx_csr #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [vtx_pkg::CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  logic [vtx_pkg::CFG_DATA_WIDTH-1:0]     csr_pwdata,
   output logic [vtx_pkg::CFG_DATA_WIDTH-1:0]     csr_prdata,
   output logic                                   csr_pready,
   output logic [vtx_pkg::NUM_REGS-1:0][vtx_pkg::CFG_DATA_WIDTH-1:0] cfg_regs_o
);
   import vtx_pkg::*;

   localparam logic [CFG_DATA_WIDTH-1:0] ONE_LO = CFG_DATA_WIDTH'(1) << FRAC_BITS;
   localparam logic [CFG_DATA_WIDTH-1:0] ONE_HI = ONE_LO << ODD_ENTRY_LSB;

   logic [CFG_DATA_WIDTH-1:0] cfg_ff [NUM_REGS];
   logic [REG_IDX_WIDTH-1:0]  reg_idx;
   logic                      wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_WIDTH-1:ADDR_LSB];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   // Register writes; reset loads the identity matrix
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[REG_ROW0_COLS01] <= ONE_LO;
         cfg_ff[REG_ROW0_COLS23] <= '0;
         cfg_ff[REG_ROW1_COLS01] <= ONE_HI;
         cfg_ff[REG_ROW1_COLS23] <= '0;
         cfg_ff[REG_ROW2_COLS01] <= '0;
         cfg_ff[REG_ROW2_COLS23] <= ONE_LO;
         cfg_ff[REG_ROW3_COLS01] <= '0;
         cfg_ff[REG_ROW3_COLS23] <= ONE_HI;
      end else if (wr_en) begin
         cfg_ff[reg_idx] <= csr_pwdata;
      end
   end

   // Read back
   assign csr_prdata = cfg_ff[reg_idx];

   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         cfg_regs_o[i] = cfg_ff[i];
      end
   end

endmodule : vtx_csr

// ===== rtl/core/vtx_lane.sv =====
// ============================================================================
// vtx_lane : one matrix row dotted with the vector
// Four signed multipliers, a registered pair of adds and a final add; the
// full-precision row sum goes on to the merge stage.
// ============================================================================
module vtx_lane #(
   parameter int WORD_WIDTH = 32
) (
   input  logic                                     clock,
   input  vtx_pkg::vtx_stage_en_type                stage_en,
   input  logic [vtx_pkg::NUM_COMP-1:0][WORD_WIDTH-1:0] coef_i,
   input  logic [vtx_pkg::NUM_COMP-1:0][WORD_WIDTH-1:0] vec_i,
   output logic [2*WORD_WIDTH+1:0]                  row_sum_o
);
   import vtx_pkg::*;

   localparam int PW = 2 * WORD_WIDTH;     // product width
   localparam int AW = PW + 1;             // pair sum width
   localparam int SW = PW + 2;             // row sum width

   logic signed [PW-1:0] prod_in [NUM_COMP];
   logic signed [PW-1:0] prod_ff [NUM_COMP];
   logic [AW-1:0]        pair_in [2];
   logic [AW-1:0]        pair_ff [2];
   logic [SW-1:0]        sum_in;
   logic [SW-1:0]        sum_ff;

   // Exact signed products
   always_comb begin
      for (int c = 0; c < NUM_COMP; c++) begin
         prod_in[c] = $signed(coef_i[c]) * $signed(vec_i[c]);
      end
   end

   // Pairwise adds, sign extended by one bit
   always_comb begin
      for (int p = 0; p < 2; p++) begin
         pair_in[p] = {prod_ff[2*p][PW-1], prod_ff[2*p]}
                    + {prod_ff[2*p+1][PW-1], prod_ff[2*p+1]};
      end
   end

   assign sum_in = {pair_ff[0][AW-1], pair_ff[0]} + {pair_ff[1][AW-1], pair_ff[1]};

   always_ff @(posedge clock) begin
      if (stage_en.mul_en) begin
         for (int c = 0; c < NUM_COMP; c++) begin
            prod_ff[c] <= prod_in[c];
         end
      end
      if (stage_en.pair_en) begin
         pair_ff[0] <= pair_in[0];
         pair_ff[1] <= pair_in[1];
      end
      if (stage_en.sum_en) begin
         sum_ff <= sum_in;
      end
   end

   assign row_sum_o = sum_ff;

endmodule : vtx_lane

// ===== rtl/core/vtx_merge.sv =====
// ============================================================================
// vtx_merge : scaling, saturation and output register
// Drops the fraction bits of each row sum (floor), clamps to the signed
// word range and packs the four rows into the output word.
// ============================================================================
module vtx_merge #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                              clock,
   input  logic                                              load_en,
   input  logic [vtx_pkg::NUM_COMP-1:0][2*WORD_WIDTH+1:0]    row_sum_i,
   output logic [vtx_pkg::TDATA_WIDTH-1:0]                   tdata_o
);
   import vtx_pkg::*;

   localparam int SW = 2 * WORD_WIDTH + 2;
   localparam logic [WORD_WIDTH-1:0] SAT_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam logic [WORD_WIDTH-1:0] SAT_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

   logic signed [SW-1:0]         shifted [NUM_COMP];
   logic signed [WORD_WIDTH-1:0] sat     [NUM_COMP];
   logic [TDATA_WIDTH-1:0]       tdata_in;
   logic [TDATA_WIDTH-1:0]       tdata_ff;

   // Arithmetic shift then clamp; in range when all upper bits match the sign
   always_comb begin
      for (int r = 0; r < NUM_COMP; r++) begin
         shifted[r] = $signed(row_sum_i[r]) >>> FRAC_BITS;
         if ((&shifted[r][SW-1:WORD_WIDTH-1]) || !(|shifted[r][SW-1:WORD_WIDTH-1])) begin
            sat[r] = shifted[r][WORD_WIDTH-1:0];
         end else if (shifted[r][SW-1]) begin
            sat[r] = SAT_MIN;
         end else begin
            sat[r] = SAT_MAX;
         end
         tdata_in[DATA_WIDTH*r +: DATA_WIDTH] = DATA_WIDTH'(sat[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         tdata_ff <= tdata_in;
      end
   end

   assign tdata_o = tdata_ff;

endmodule : vtx_merge

// ===== rtl/core/vertex_transform_4x4.sv =====
// ============================================================================
// vertex_transform_4x4 : streaming 4x4 matrix times 4-vector transform
// Top level: register file, four row lanes, merge stage and flow control.
// ============================================================================
// One vector is taken per clock and one transformed vector leaves per clock while rsp_tready is high.
// An accepted vector passes through four register stages (multiply, pair add,
// row add, scale and clamp) before its result is presented.
// Every stage holds its own valid bit and moves on when the stage ahead is
// empty or emptying, so a stall on the result side only stops the input once
// all four stages are full. Each output row is floor(sum(M[r][c]*v[c]) /
// 2^FRAC_BITS) clamped to the signed WORD_WIDTH range and sign extended to
// 32 bits. The matrix registers (reset: identity) must be written only while
// no transaction is in flight.
module vertex_transform_4x4 #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input vectors
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [vtx_pkg::TDATA_WIDTH-1:0]     req_tdata,  // x_in, y_in, z_in, w_in
   input  logic                                req_tlast,  // last_in
   // Transformed vectors
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [vtx_pkg::TDATA_WIDTH-1:0]     rsp_tdata,  // x_out, y_out, z_out, w_out
   output logic                                rsp_tlast,  // last_out
   // Register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [vtx_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [vtx_pkg::CFG_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [vtx_pkg::CFG_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import vtx_pkg::*;

   localparam int SW = 2 * WORD_WIDTH + 2;

   logic [NUM_REGS-1:0][CFG_DATA_WIDTH-1:0]             cfg_regs;
   logic [NUM_COMP-1:0][WORD_WIDTH-1:0]                 vec;
   logic [NUM_COMP-1:0][NUM_COMP-1:0][WORD_WIDTH-1:0]   row_coef;
   logic [NUM_COMP-1:0][SW-1:0]                         row_sum;
   logic [NUM_STG-1:0]  valid_ff, valid_in;
   logic [NUM_STG-1:0]  last_ff, last_in;
   logic [NUM_STG-1:0]  load;
   vtx_stage_en_type    stage_en;

   // Matrix registers
   vtx_csr #(
      .FRAC_BITS (FRAC_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg_regs_o  (cfg_regs)
   );

   // Unpack vector components and matrix entries (low WORD_WIDTH bits used)
   always_comb begin
      for (int c = 0; c < NUM_COMP; c++) begin
         vec[c] = req_tdata[DATA_WIDTH*c +: WORD_WIDTH];
      end
      for (int r = 0; r < NUM_COMP; r++) begin
         row_coef[r][0] = cfg_regs[2*r][WORD_WIDTH-1:0];
         row_coef[r][1] = cfg_regs[2*r][ODD_ENTRY_LSB +: WORD_WIDTH];
         row_coef[r][2] = cfg_regs[2*r+1][WORD_WIDTH-1:0];
         row_coef[r][3] = cfg_regs[2*r+1][ODD_ENTRY_LSB +: WORD_WIDTH];
      end
   end

   // Flow control: a stage loads when it is empty or its content moves on
   always_comb begin
      load[STG_OUT]  = !valid_ff[STG_OUT]  || rsp_tready;
      load[STG_SUM]  = !valid_ff[STG_SUM]  || load[STG_OUT];
      load[STG_PAIR] = !valid_ff[STG_PAIR] || load[STG_SUM];
      load[STG_MUL]  = !valid_ff[STG_MUL]  || load[STG_PAIR];
   end

   assign req_tready = load[STG_MUL];

   assign stage_en.mul_en  = load[STG_MUL]  & req_tvalid;
   assign stage_en.pair_en = load[STG_PAIR] & valid_ff[STG_MUL];
   assign stage_en.sum_en  = load[STG_SUM]  & valid_ff[STG_PAIR];

   always_comb begin
      valid_in = valid_ff;
      last_in  = last_ff;
      if (load[STG_MUL]) begin
         valid_in[STG_MUL] = req_tvalid;
         last_in[STG_MUL]  = req_tlast;
      end
      for (int s = 1; s < NUM_STG; s++) begin
         if (load[s]) begin
            valid_in[s] = valid_ff[s-1];
            last_in[s]  = last_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
   end

   // One lane per matrix row
   for (genvar r = 0; r < NUM_COMP; r++) begin : g_lane
      vtx_lane #(
         .WORD_WIDTH (WORD_WIDTH)
      ) u_lane (
         .clock     (clock),
         .stage_en  (stage_en),
         .coef_i    (row_coef[r]),
         .vec_i     (vec),
         .row_sum_o (row_sum[r])
      );
   end

   // Scale, clamp and register the result
   vtx_merge #(
      .WORD_WIDTH (WORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_merge (
      .clock     (clock),
      .load_en   (load[STG_OUT] & valid_ff[STG_SUM]),
      .row_sum_i (row_sum),
      .tdata_o   (rsp_tdata)
   );

   assign rsp_tvalid = valid_ff[STG_OUT];
   assign rsp_tlast  = last_ff[STG_OUT];

`ifndef SYNTH
   // An accepted transaction always enters the multiply stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[STG_MUL])
      else $error("accepted vector lost at multiply stage");

   // A full pipeline with a stalled result must hold off the input
   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && !rsp_tready) |-> !req_tready)
      else $error("input accepted while pipeline full and stalled");

   // The batch mark follows its vector into the output register
   a_last_follows: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && $past(valid_ff[STG_SUM]) && $past(load[STG_OUT]))
      |-> (rsp_tvalid && (rsp_tlast == $past(last_ff[STG_SUM]))))
      else $error("last flag out of step with result");
`endif

endmodule : vertex_transform_4x4
